### design/pcsm_pkg.sv
// pcsm_pkg: shared constants, types and tables for the cluster sieve marker
// no dependencies; imported by every design file of the block but pcsm_ram
`timescale 1ns / 1ps

package pcsm_pkg;

  localparam int SIEVE_WORDS_DEF = 16384;
  localparam int PRIME_BITS_DEF  = 27;
  localparam int SIZE_W          = 21;
  localparam int INDEX_W         = 14;
  localparam int OP_W            = 2;
  localparam int WORD_W          = 64;
  localparam int BIT_SEL_W       = 6;
  localparam int NUM_OFFSETS     = 5;
  localparam int OFF_IDX_W       = 3;
  localparam int OFF_W           = 6;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 21'd1048576;

  // operation codes of an input beat
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // cluster offsets: the short set uses the first two
  localparam logic [OFF_W-1:0] CLUSTER_OFFSETS [NUM_OFFSETS] = '{
    6'd18, 6'd20, 6'd26, 6'd30, 6'd32
  };
  localparam logic [OFF_IDX_W-1:0] LAST_SHORT = 3'd1;
  localparam logic [OFF_IDX_W-1:0] LAST_FULL  = 3'd4;

  // command kinds after classification
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_MARK,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  // queue head status toward the back end
  typedef struct packed {
    logic      valid;
    cmd_kind_t kind;
    logic      full_set;
  } cmd_head_t;

endpackage

### design/prime_cluster_sieve_marker.sv
// prime_cluster_sieve_marker: top level of the cluster sieve marker
// depends on pcsm_pkg, pcsm_front, pcsm_back, pcsm_ram
//
// usage
//   input: a beat is taken when start is high and busy is low. operation picks
//   clear (zero the sieve), mark (strike one prime at each offset of the chosen cluster set) or
//   read (return one 64-bit sieve word). a two-entry queue sits ahead of the
//   engine, so busy drops while the engine still works on earlier beats.
//   output: every beat gives one result, shown for one cycle with out_strobe;
//   out_sieve_word is the read word, zero for clear, mark and unknown codes.
//   the receiver cannot stall; results leave in beat order.
//   config: cfg_wr_en writes cfg_wr_data into the sieve size; the user must
//   write it only while idle, which the block itself does not enforce.
// engine
//   read: the ram word is read and registered before out_strobe shows it.
//   clear: one ram word per cycle, over every sieve word.
//   mark: per offset a bit-serial modular multiply, then for each struck bit a
//   ram read and a write back, then the walk end; all share the single ram write port.
// reset
//   reset runs a clearing pass over all SIEVE_WORDS words; busy stays high meanwhile.
`timescale 1ns / 1ps

module prime_cluster_sieve_marker #(
  parameter int SIEVE_WORDS = pcsm_pkg::SIEVE_WORDS_DEF,
  parameter int PRIME_BITS  = pcsm_pkg::PRIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pcsm_pkg::OP_W-1:0]    in_operation,
  input  logic [PRIME_BITS-1:0]        in_prime,
  input  logic [PRIME_BITS-1:0]        in_inverse,
  input  logic [PRIME_BITS-1:0]        in_base_remainder,
  input  logic                         in_offset_set,
  input  logic [pcsm_pkg::INDEX_W-1:0] in_word_index,
  input  logic                         cfg_wr_en,
  input  logic [pcsm_pkg::SIZE_W-1:0]  cfg_wr_data,
  output logic                         out_strobe,
  output logic [pcsm_pkg::WORD_W-1:0]  out_sieve_word
);
  import pcsm_pkg::*;

  localparam int AW = (SIEVE_WORDS > 1) ? $clog2(SIEVE_WORDS) : 1;

  logic [SIZE_W-1:0]     size_r;
  cmd_head_t             head;
  logic [PRIME_BITS-1:0] head_prime, head_inverse, head_base;
  logic [INDEX_W-1:0]    head_index;
  logic                  pop, init_busy;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;

  // sieve size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  pcsm_front #(.SIEVE_WORDS(SIEVE_WORDS), .PRIME_BITS(PRIME_BITS)) u_front (
    .clk, .rst_n, .start, .hold(init_busy), .busy,
    .in_operation, .in_prime, .in_inverse, .in_base_remainder,
    .in_offset_set, .in_word_index, .pop, .head,
    .head_prime, .head_inverse, .head_base, .head_index
  );

  pcsm_back #(.SIEVE_WORDS(SIEVE_WORDS), .PRIME_BITS(PRIME_BITS)) u_back (
    .clk, .rst_n, .head, .head_prime, .head_inverse, .head_base, .head_index,
    .pop, .init_busy, .sieve_size(size_r),
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata,
    .out_strobe, .out_sieve_word
  );

  pcsm_ram #(.WIDTH(WORD_W), .DEPTH(SIEVE_WORDS)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

endmodule

### design/pcsm_ram.sv
// pcsm_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module pcsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/pcsm_front.sv
// pcsm_front: accepts input beats, classifies them and holds them in a two-entry queue
// depends on pcsm_pkg
`timescale 1ns / 1ps

module pcsm_front #(
  parameter int SIEVE_WORDS = pcsm_pkg::SIEVE_WORDS_DEF,
  parameter int PRIME_BITS  = pcsm_pkg::PRIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         hold,
  output logic                         busy,
  input  logic [pcsm_pkg::OP_W-1:0]    in_operation,
  input  logic [PRIME_BITS-1:0]        in_prime,
  input  logic [PRIME_BITS-1:0]        in_inverse,
  input  logic [PRIME_BITS-1:0]        in_base_remainder,
  input  logic                         in_offset_set,
  input  logic [pcsm_pkg::INDEX_W-1:0] in_word_index,
  input  logic                         pop,
  output pcsm_pkg::cmd_head_t          head,
  output logic [PRIME_BITS-1:0]        head_prime,
  output logic [PRIME_BITS-1:0]        head_inverse,
  output logic [PRIME_BITS-1:0]        head_base,
  output logic [pcsm_pkg::INDEX_W-1:0] head_index
);
  import pcsm_pkg::*;

  localparam int EW = 2 + 1 + 3 * PRIME_BITS + INDEX_W;

  logic [EW-1:0] q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  cmd_kind_t     kind;
  logic [EW-1:0] entry;
  logic [EW-1:0] head_entry;

  // classify: marks with a zero prime, reads beyond storage and unknown codes do nothing
  always_comb begin
    case (in_operation)
      OP_CLEAR: kind = CMD_CLEAR;
      OP_MARK:  kind = (in_prime == '0) ? CMD_NOP : CMD_MARK;
      OP_READ:  kind = (32'(in_word_index) < 32'(SIEVE_WORDS)) ? CMD_READ : CMD_NOP;
      default:  kind = CMD_NOP;
    endcase
  end

  assign entry = {kind, in_offset_set, in_prime, in_inverse, in_base_remainder,
                  in_word_index};
  assign busy  = (cnt_r == 2'd2) || hold;
  assign push  = start && !busy;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

  // head of the queue
  assign head_entry = q_r[rd_ptr_r];
  always_comb begin
    head.valid    = (cnt_r != 2'd0);
    head.kind     = cmd_kind_t'(head_entry[EW-1 -: 2]);
    head.full_set = head_entry[EW-3];
    head_prime    = head_entry[INDEX_W + 3*PRIME_BITS - 1 -: PRIME_BITS];
    head_inverse  = head_entry[INDEX_W + 2*PRIME_BITS - 1 -: PRIME_BITS];
    head_base     = head_entry[INDEX_W + PRIME_BITS - 1 -: PRIME_BITS];
    head_index    = head_entry[INDEX_W-1:0];
  end

endmodule

### design/pcsm_back.sv
// pcsm_back: executes queued commands against the sieve ram (clear sweep,
// modular start search and strike walk, word read); depends on pcsm_pkg
`timescale 1ns / 1ps

module pcsm_back #(
  parameter int SIEVE_WORDS = pcsm_pkg::SIEVE_WORDS_DEF,
  parameter int PRIME_BITS  = pcsm_pkg::PRIME_BITS_DEF,
  localparam int AW = (SIEVE_WORDS > 1) ? $clog2(SIEVE_WORDS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcsm_pkg::cmd_head_t          head,
  input  logic [PRIME_BITS-1:0]        head_prime,
  input  logic [PRIME_BITS-1:0]        head_inverse,
  input  logic [PRIME_BITS-1:0]        head_base,
  input  logic [pcsm_pkg::INDEX_W-1:0] head_index,
  output logic                         pop,
  output logic                         init_busy,
  input  logic [pcsm_pkg::SIZE_W-1:0]  sieve_size,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [pcsm_pkg::WORD_W-1:0]  ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  logic [pcsm_pkg::WORD_W-1:0]  ram_rdata,
  output logic                         out_strobe,
  output logic [pcsm_pkg::WORD_W-1:0]  out_sieve_word
);
  import pcsm_pkg::*;

  localparam int STORE_BITS = SIEVE_WORDS * 64;
  localparam int LIM_W_RAW  = $clog2(STORE_BITS + 1);
  localparam int LIM_W      = (LIM_W_RAW > SIZE_W) ? LIM_W_RAW : SIZE_W;
  localparam int POS_W      = ((LIM_W > PRIME_BITS) ? LIM_W : PRIME_BITS) + 1;
  localparam int PB1        = PRIME_BITS + 1;
  localparam int BIT_W      = (PRIME_BITS > 1) ? $clog2(PRIME_BITS) : 1;
  localparam logic [AW-1:0]    LAST_WORD = AW'(SIEVE_WORDS - 1);
  localparam logic [LIM_W-1:0] STORE_LIM = LIM_W'(STORE_BITS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_RDA, S_RDD, S_REM, S_FOLD, S_DIFF,
    S_DBL, S_ADD, S_WRD, S_WWR, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic [PRIME_BITS-1:0]  p_r, p_nxt;
  logic [PRIME_BITS-1:0]  inv_r, inv_nxt;
  logic [PRIME_BITS-1:0]  base_r, base_nxt;
  logic [INDEX_W-1:0]     idx_r, idx_nxt;
  logic                   full_r, full_nxt;
  logic [LIM_W-1:0]       lim_r, lim_nxt;
  logic [OFF_IDX_W-1:0]   k_r, k_nxt;
  logic [PB1-1:0]         rem_r, rem_nxt;
  logic [PRIME_BITS-1:0]  diff_r, diff_nxt;
  logic [PRIME_BITS-1:0]  acc_r, acc_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  logic [WORD_W-1:0]      out_word_r, out_word_nxt;

  logic [PB1-1:0]         p_ext;
  logic [PB1-1:0]         dbl;
  logic [PB1-1:0]         sum;
  logic [LIM_W-1:0]       size_ext;
  logic [AW-1:0]          pos_word;

  assign p_ext    = {1'b0, p_r};
  assign dbl      = {acc_r, 1'b0};
  assign sum      = {1'b0, acc_r} + {1'b0, diff_r};
  assign size_ext = LIM_W'(sieve_size);
  assign pos_word = pos_r[AW+BIT_SEL_W-1:BIT_SEL_W];

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    p_nxt          = p_r;
    inv_nxt        = inv_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    full_nxt       = full_r;
    lim_nxt        = lim_r;
    k_nxt          = k_r;
    rem_nxt        = rem_r;
    diff_nxt       = diff_r;
    acc_nxt        = acc_r;
    bit_nxt        = bit_r;
    pos_nxt        = pos_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = '0;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pos_word;
    ram_wdata      = ram_rdata | (WORD_W'(1) << pos_r[BIT_SEL_W-1:0]);
    ram_raddr      = pos_word;

    case (state_r)
      // clearing pass after reset and for a clear beat
      S_INIT, S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == LAST_WORD) begin
          clr_addr_nxt = '0;
          state_nxt    = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      // take the next command from the queue
      S_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          p_nxt    = head_prime;
          inv_nxt  = head_inverse;
          base_nxt = head_base;
          idx_nxt  = head_index;
          full_nxt = head.full_set;
          lim_nxt  = (size_ext > STORE_LIM) ? STORE_LIM : size_ext;
          k_nxt    = '0;
          case (head.kind)
            CMD_CLEAR: state_nxt = S_CLR;
            CMD_MARK:  state_nxt = S_REM;
            CMD_READ:  state_nxt = S_RDA;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      // word read
      S_RDA: begin
        ram_raddr = AW'(idx_r);
        state_nxt = S_RDD;
      end
      S_RDD: begin
        out_strobe_nxt = 1'b1;
        out_word_nxt   = ram_rdata;
        state_nxt      = S_IDLE;
      end
      // remainder of base plus offset, folded once
      S_REM: begin
        rem_nxt   = {1'b0, base_r} + PB1'(CLUSTER_OFFSETS[k_r]);
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        if (rem_r > p_ext) begin
          rem_nxt = rem_r - p_ext;
        end
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        diff_nxt  = (rem_r <= p_ext) ? PRIME_BITS'(p_ext - rem_r) : '0;
        acc_nxt   = '0;
        bit_nxt   = BIT_W'(PRIME_BITS - 1);
        state_nxt = S_DBL;
      end
      // shift-add modular multiply, msb of the inverse first
      S_DBL: begin
        acc_nxt   = (dbl >= p_ext) ? PRIME_BITS'(dbl - p_ext) : PRIME_BITS'(dbl);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (inv_r[bit_r]) begin
          acc_nxt = (sum >= p_ext) ? PRIME_BITS'(sum - p_ext) : PRIME_BITS'(sum);
        end
        if (bit_r == '0) begin
          pos_nxt   = POS_W'(acc_nxt);
          state_nxt = S_WRD;
        end else begin
          bit_nxt   = bit_r - BIT_W'(1);
          state_nxt = S_DBL;
        end
      end
      // strike walk: read the word, then write it back with the bit set
      S_WRD: begin
        if (pos_r < POS_W'(lim_r)) begin
          state_nxt = S_WWR;
        end else if (k_r == (full_r ? LAST_FULL : LAST_SHORT)) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + OFF_IDX_W'(1);
          state_nxt = S_REM;
        end
      end
      S_WWR: begin
        ram_we    = 1'b1;
        pos_nxt   = pos_r + POS_W'(p_r);
        state_nxt = S_WRD;
      end
      // result beat with a zero word
      S_DONE: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      clr_addr_r   <= '0;
      out_strobe_r <= 1'b0;
      out_word_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_word_r   <= out_word_nxt;
    end
    p_r    <= p_nxt;
    inv_r  <= inv_nxt;
    base_r <= base_nxt;
    idx_r  <= idx_nxt;
    full_r <= full_nxt;
    lim_r  <= lim_nxt;
    k_r    <= k_nxt;
    rem_r  <= rem_nxt;
    diff_r <= diff_nxt;
    acc_r  <= acc_nxt;
    bit_r  <= bit_nxt;
    pos_r  <= pos_nxt;
  end

  assign init_busy      = (state_r == S_INIT);
  assign out_strobe     = out_strobe_r;
  assign out_sieve_word = out_word_r;

endmodule

### design/pcsm_chk.sv
// pcsm_chk: port-level checks on the cluster sieve marker, bound to the top
// depends on pcsm_pkg and prime_cluster_sieve_marker
`timescale 1ns / 1ps

module pcsm_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         busy,
  input logic                         out_strobe,
  input logic [pcsm_pkg::WORD_W-1:0]  out_sieve_word
);

  // the clearing pass holds off input right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> busy)
    else $error("busy low right after reset");

  // no result beat comes straight out of reset
  a_no_result_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rst_n))
    else $error("result beat right after reset");

  // result beats never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result beats in a row");

  // the word is quiet between beats
  a_word_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_strobe |-> out_sieve_word == '0)
    else $error("result word nonzero without strobe");

endmodule

bind prime_cluster_sieve_marker pcsm_chk u_chk (.*);

### sim/prime_cluster_sieve_marker_test.sv
// prime_cluster_sieve_marker_test: self-checking testbench of the cluster sieve marker
// depends on pcsm_pkg and prime_cluster_sieve_marker; keeps its own sieve image
`timescale 1ns / 1ps

module prime_cluster_sieve_marker_test;
  import pcsm_pkg::*;

  localparam int NWORDS = SIEVE_WORDS_DEF;
  localparam int PBITS  = PRIME_BITS_DEF;
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     in_operation = OP_CLEAR;
  logic [PBITS-1:0]    in_prime = '0;
  logic [PBITS-1:0]    in_inverse = '0;
  logic [PBITS-1:0]    in_base_remainder = '0;
  logic                in_offset_set = 1'b0;
  logic [INDEX_W-1:0]  in_word_index = '0;
  logic                cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]   cfg_wr_data = '0;
  logic                out_strobe;
  logic [WORD_W-1:0]   out_sieve_word;

  // own image of the block
  logic [WORD_W-1:0]   struck_words [NWORDS];
  longint unsigned     size_in_use;
  logic [WORD_W-1:0]   pending_words [$];
  int                  errors = 0;
  int                  send_idle_pct = 0;

  prime_cluster_sieve_marker DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_prime(in_prime), .in_inverse(in_inverse),
    .in_base_remainder(in_base_remainder), .in_offset_set(in_offset_set),
    .in_word_index(in_word_index), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_strobe(out_strobe), .out_sieve_word(out_sieve_word)
  );

  always #2 clk = ~clk;

  // strike one cluster offset of a prime in the image
  task automatic strike_offset(longint unsigned p, longint unsigned inv,
                               longint unsigned base, longint unsigned off,
                               longint unsigned limit);
    longint unsigned rem;
    longint unsigned diff;
    longint unsigned pos;
    rem = base + off;
    if (rem > p) rem = rem - p;
    diff = (rem <= p) ? (p - rem) : 0;
    diff = diff % p;
    pos = (diff * inv) % p;
    while (pos < limit) begin
      struck_words[pos >> 6][pos & 63] = 1'b1;
      pos = pos + p;
    end
  endtask

  // apply one beat to the image and return the word it reads
  task automatic predict_beat(logic [OP_W-1:0] op, longint unsigned p,
                              longint unsigned inv, longint unsigned base,
                              logic full, int unsigned idx,
                              output logic [WORD_W-1:0] word);
    longint unsigned limit;
    int n;
    limit = size_in_use;
    if (limit > 64 * NWORDS) limit = 64 * NWORDS;
    word = '0;
    case (op)
      OP_CLEAR: begin
        foreach (struck_words[i]) struck_words[i] = '0;
      end
      OP_MARK: begin
        if (p != 0) begin
          inv = inv % p;
          n = full ? NUM_OFFSETS : 2;
          for (int k = 0; k < n; k++)
            strike_offset(p, inv, base, CLUSTER_OFFSETS[k], limit);
        end
      end
      OP_READ: begin
        if (idx < NWORDS) word = struck_words[idx];
      end
      default: ;
    endcase
  endtask

  // send one beat, with random sender gaps ahead of it
  task automatic send_beat(logic [OP_W-1:0] op, logic [PBITS-1:0] p,
                           logic [PBITS-1:0] inv, logic [PBITS-1:0] base,
                           logic full, logic [INDEX_W-1:0] idx);
    logic [WORD_W-1:0] word;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_prime <= p;
    in_inverse <= inv;
    in_base_remainder <= base;
    in_offset_set <= full;
    in_word_index <= idx;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_beat(op, p, inv, base, full, idx, word);
    pending_words = {pending_words, word};
  endtask

  // wait for every result, then let the engine settle
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_sieve_size(logic [SIZE_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_in_use = value;
  endtask

  // check each result beat against the oldest expectation
  always @(negedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_words.size() == 0) begin
        $error("sieve_word: unexpected result %h", out_sieve_word);
        errors++;
      end else begin
        if (out_sieve_word !== pending_words[0]) begin
          $error("sieve_word: expected %h actual %h", pending_words[0], out_sieve_word);
          errors++;
        end
        void'(pending_words.pop_front());
      end
    end
  end

  // reset-size and beyond-storage sizes with large primes
  task automatic test_large_sizes;
    send_beat(OP_READ, 0, 0, 0, 0, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 14'h3FFF);
    send_beat(OP_MARK, 27'h7FFFFFF, 27'h7FFFFFF, 27'h7FFFFFF, 1, 0);
    send_beat(OP_MARK, 27'd1000003, 27'd12345, 27'd7, 1, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 0);
    set_sieve_size(21'h1FFFFF);
    send_beat(OP_MARK, 27'd1048573, 27'd999, 27'd0, 1, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 14'h3FFF);
    send_beat(OP_READ, 0, 0, 0, 0, 14'd15);
  endtask

  // small size: zero prime, short set, out-of-range remainder and inverse
  task automatic test_special_marks;
    set_sieve_size(21'd64);
    send_beat(OP_MARK, 0, 27'd5, 27'd3, 1, 0);
    send_beat(OP_MARK, 27'd3, 27'd2, 27'd1, 0, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 0);
    send_beat(OP_MARK, 27'd7, 27'd50, 27'd100, 1, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 1);
    send_beat(OP_UNDEF, 27'h7FFFFFF, 27'h7FFFFFF, 27'h7FFFFFF, 1, 14'h3FFF);
    send_beat(OP_CLEAR, 0, 0, 0, 0, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 0);
    send_beat(OP_READ, 0, 0, 0, 0, 14'd15);
  endtask

  // random beats, mostly marks and reads near the live part of the sieve
  task automatic test_random(int pct, int count, logic [SIZE_W-1:0] size_val);
    logic [OP_W-1:0] op;
    logic [PBITS-1:0] p, inv, base;
    logic [INDEX_W-1:0] idx;
    int sel;
    set_sieve_size(size_val);
    send_idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      op = (sel < 1) ? OP_CLEAR : (sel < 3) ? OP_UNDEF : (sel < 50) ? OP_MARK : OP_READ;
      sel = $urandom_range(99);
      if (sel < 30 && size_val <= 1024) p = PBITS'($urandom_range(64, 1));
      else if (sel < 60) p = PBITS'($urandom_range(2000, 65));
      else if (sel < 90) p = PBITS'($urandom_range(27'h7FFFFFF, 2001));
      else p = PBITS'($urandom);
      if (p != 0 && $urandom_range(9) != 0) begin
        inv = PBITS'($urandom_range(p - 1, 0));
        base = PBITS'($urandom_range(p - 1, 0));
      end else begin
        inv = PBITS'($urandom);
        base = PBITS'($urandom);
      end
      if ($urandom_range(9) < 7) idx = INDEX_W'($urandom_range((size_val - 1) / 64, 0));
      else idx = INDEX_W'($urandom);
      send_beat(op, p, inv, base, 1'($urandom_range(1)), idx);
    end
    drain();
  endtask

  initial begin
    foreach (struck_words[i]) struck_words[i] = '0;
    size_in_use = SIZE_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_large_sizes();
    test_special_marks();
    test_random(0, 110, 21'd64);
    test_random(0, 110, SIZE_W'($urandom_range(1024, 65)));
    test_random(49, 110, 21'd1024);
    test_random(49, 110, SIZE_W'($urandom_range(1024, 64)));
    test_random(0, 110, 21'd4096);
    test_random(0, 110, 21'd200);
    test_random(28, 110, 21'd512);
    test_random(28, 110, 21'd64);
    if (errors == 0) begin
      $display("prime_cluster_sieve_marker_test: done, clean");
    end else begin
      $display("prime_cluster_sieve_marker_test: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("prime_cluster_sieve_marker_test: done, errors");
    $finish;
  end

endmodule
